// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication outside reset.
`define CHK_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cmc_pkg.sv =====
`default_nettype none
package cmc_pkg;
	localparam int MatrixDimDef = 4;
	localparam int FracBitsDef  = 16;
	localparam int AddrSpan     = 4;
	localparam int IdxW         = 2;
	localparam int ValW         = 32;
	localparam int AccW         = 64;
	localparam int QueueDepth   = 2;

	typedef enum logic [1:0] {
		CMD_LOAD_H = 2'd0,
		CMD_LOAD_S = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MAC,
		ST_EMIT
	} be_state_t;

	// One classified job from the front end.
	typedef struct packed {
		logic             is_load_h;
		logic             is_load_s;
		logic             is_compute;
		logic [IdxW-1:0]  row;
		logic [IdxW-1:0]  col;
		logic [ValW-1:0]  v_re;
		logic [ValW-1:0]  v_im;
		logic [ValW-1:0]  p_re;
		logic [ValW-1:0]  p_im;
	} job_t;

	function automatic logic [ValW-1:0] sat32(input logic signed [AccW-1:0] v,
		output logic clipped);
		logic signed [AccW-1:0] mx;
		logic signed [AccW-1:0] mn;
		mx = AccW'(64'sh7FFF_FFFF);
		mn = -AccW'(64'sh8000_0000);
		clipped = 1'b0;
		if (v > mx) begin
			clipped = 1'b1;
			return 32'h7FFF_FFFF;
		end else if (v < mn) begin
			clipped = 1'b1;
			return 32'h8000_0000;
		end
		return v[ValW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/cmc_ram.sv =====
`default_nettype none
module cmc_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/cmc_front.sv =====
`default_nettype none
module cmc_front
	import cmc_pkg::*;
#(
	parameter int MatrixDim = MatrixDimDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      cmd,
	input  wire logic [IdxW-1:0] row,
	input  wire logic [IdxW-1:0] col,
	input  wire logic [ValW-1:0] v_re,
	input  wire logic [ValW-1:0] v_im,
	input  wire logic [ValW-1:0] p_re,
	input  wire logic [ValW-1:0] p_im,
	output logic                 job_valid,
	input  wire logic            job_ready,
	output job_t                 job
);
	localparam int EffDim = (MatrixDim < AddrSpan) ? MatrixDim : AddrSpan;
	localparam int PtrW   = $clog2(QueueDepth);

	job_t             fifo_q [QueueDepth];
	logic [PtrW-1:0]  wp_q, rp_q;
	logic [PtrW:0]    cnt_q;
	logic             in_rng, keep, push, pop;
	job_t             nj;

	always_comb begin
		in_rng = (32'(row) < EffDim) && (32'(col) < EffDim);
		nj = '0;
		nj.is_load_h  = (cmd == CMD_LOAD_H) && in_rng;
		nj.is_load_s  = (cmd == CMD_LOAD_S) && in_rng;
		nj.is_compute = (cmd == CMD_COMPUTE);
		nj.row  = row;
		nj.col  = col;
		nj.v_re = v_re;
		nj.v_im = v_im;
		nj.p_re = p_re;
		nj.p_im = p_im;
		keep = nj.is_load_h || nj.is_load_s || nj.is_compute;
	end

	assign in_ready  = (cnt_q != (PtrW+1)'(QueueDepth));
	assign push      = in_valid && in_ready && keep;
	assign job_valid = (cnt_q != '0);
	assign pop       = job_valid && job_ready;
	assign job       = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= nj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (32'(wp_q) == QueueDepth-1) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (32'(rp_q) == QueueDepth-1) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/cmc_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module cmc_back
	import cmc_pkg::*;
#(
	parameter int MatrixDim = MatrixDimDef,
	parameter int FracBits  = FracBitsDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	output logic                 job_ready,
	input  job_t                 job,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [IdxW-1:0]      o_row,
	output logic [IdxW-1:0]      o_col,
	output logic [ValW-1:0]      o_re,
	output logic [ValW-1:0]      o_im,
	output logic                 o_sat,
	output logic                 o_last
);
	localparam int EffDim = (MatrixDim < AddrSpan) ? MatrixDim : AddrSpan;
	localparam int AW     = 2 * IdxW;
	localparam int PW     = 2 * ValW;

	be_state_t st_q, st_d;
	logic [IdxW-1:0] i_q, j_q, k_q;
	logic            last_k_s1, last_k_s2, mac_s1, mac_s2;
	logic            fetch_s1, issue;
	logic signed [AccW-1:0] acc_re_q, acc_im_q;

	// Two read ports for H and for S, one for the prior: A port at (i,k), B port at (k,j) or (i,j).
	logic            we_h, we_s;
	logic [AW-1:0]   wa, ra_a, ra_b;
	logic [ValW-1:0] hr_a, hi_a, sr_a, si_a, hr_b, hi_b, sr_b, si_b, pr_b, pi_b;

	assign wa   = {job.row, job.col};
	assign we_h = (st_q == ST_IDLE) && job_valid && job.is_load_h;
	assign we_s = (st_q == ST_IDLE) && job_valid && job.is_load_s;
	assign ra_a = {i_q, k_q};
	assign ra_b = (st_q == ST_MAC) ? {k_q, j_q} : {i_q, j_q};

	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_hra (.clk, .we(we_h),
		.waddr(wa), .wdata(job.v_re), .raddr(ra_a), .rdata(hr_a));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_hia (.clk, .we(we_h),
		.waddr(wa), .wdata(job.v_im), .raddr(ra_a), .rdata(hi_a));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_sra (.clk, .we(we_s),
		.waddr(wa), .wdata(job.v_re), .raddr(ra_a), .rdata(sr_a));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_sia (.clk, .we(we_s),
		.waddr(wa), .wdata(job.v_im), .raddr(ra_a), .rdata(si_a));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_hrb (.clk, .we(we_h),
		.waddr(wa), .wdata(job.v_re), .raddr(ra_b), .rdata(hr_b));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_hib (.clk, .we(we_h),
		.waddr(wa), .wdata(job.v_im), .raddr(ra_b), .rdata(hi_b));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_srb (.clk, .we(we_s),
		.waddr(wa), .wdata(job.v_re), .raddr(ra_b), .rdata(sr_b));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_sib (.clk, .we(we_s),
		.waddr(wa), .wdata(job.v_im), .raddr(ra_b), .rdata(si_b));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_prb (.clk, .we(we_s),
		.waddr(wa), .wdata(job.p_re), .raddr(ra_b), .rdata(pr_b));
	cmc_ram #(.Width(ValW), .Depth(AddrSpan*AddrSpan)) u_pib (.clk, .we(we_s),
		.waddr(wa), .wdata(job.p_im), .raddr(ra_b), .rdata(pi_b));

	// Eight products, registered, floored by arithmetic shift.
	logic signed [PW-1:0] pr_s2 [8];
	always_ff @(posedge clk) begin
		pr_s2[0] <= ($signed(hr_a) * $signed(si_b)) >>> FracBits;
		pr_s2[1] <= ($signed(sr_a) * $signed(hi_b)) >>> FracBits;
		pr_s2[2] <= ($signed(hi_a) * $signed(sr_b)) >>> FracBits;
		pr_s2[3] <= ($signed(si_a) * $signed(hr_b)) >>> FracBits;
		pr_s2[4] <= ($signed(hr_a) * $signed(sr_b)) >>> FracBits;
		pr_s2[5] <= ($signed(sr_a) * $signed(hr_b)) >>> FracBits;
		pr_s2[6] <= ($signed(hi_a) * $signed(si_b)) >>> FracBits;
		pr_s2[7] <= ($signed(si_a) * $signed(hi_b)) >>> FracBits;
	end

	logic signed [AccW-1:0] sum_re, sum_im;
	assign sum_re = AccW'(pr_s2[0]) - AccW'(pr_s2[1]) + AccW'(pr_s2[2]) - AccW'(pr_s2[3]);
	assign sum_im = AccW'(pr_s2[5]) - AccW'(pr_s2[4]) + AccW'(pr_s2[6]) - AccW'(pr_s2[7]);

	logic last_i, last_j, last_k;
	assign last_i = (32'(i_q) == EffDim-1);
	assign last_j = (32'(j_q) == EffDim-1);
	assign last_k = (32'(k_q) == EffDim-1);

	// one k read per cycle, from the first MAC cycle until the last k is out
	assign issue = (st_q == ST_MAC) && (fetch_s1 || mac_s1) && !last_k_s1;

	always_comb begin
		st_d      = st_q;
		job_ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_ready = 1'b1;
					if (job.is_compute) begin
						st_d = ST_FETCH;
					end
				end
			end
			// read prior at (i,j) first
			ST_FETCH: st_d = ST_MAC;
			ST_MAC: begin
				if (last_k_s2) begin
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid || out_ready) begin
					st_d = (last_i && last_j) ? ST_IDLE : ST_FETCH;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			mac_s1    <= 1'b0;
			mac_s2    <= 1'b0;
			last_k_s1 <= 1'b0;
			last_k_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			st_q      <= st_d;
			if (st_q == ST_IDLE && st_d == ST_FETCH) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			mac_s1    <= issue;
			last_k_s1 <= issue && last_k;
			mac_s2    <= mac_s1;
			last_k_s2 <= last_k_s1;
			if (issue) begin
				k_q <= last_k ? '0 : k_q + 1'b1;
			end
			if (st_q == ST_EMIT && st_d != ST_EMIT) begin
				k_q <= '0;
				j_q <= last_j ? '0 : j_q + 1'b1;
				if (last_j) begin
					i_q <= i_q + 1'b1;
				end
			end
			if (st_q == ST_EMIT && st_d != ST_EMIT) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// accumulator: prior loaded from the B port in the cycle after FETCH
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s1 <= 1'b0;
		end else begin
			fetch_s1 <= (st_q == ST_FETCH);
		end
	end

	logic sre, sim;
	logic [ValW-1:0] rre, rim;
	always_comb begin
		rre = sat32(acc_re_q, sre);
		rim = sat32(acc_im_q, sim);
	end

	always_ff @(posedge clk) begin
		if (fetch_s1) begin
			acc_re_q <= AccW'($signed(pr_b));
			acc_im_q <= AccW'($signed(pi_b));
		end else if (mac_s2) begin
			acc_re_q <= acc_re_q + sum_re;
			acc_im_q <= acc_im_q + sum_im;
		end
		if (st_q == ST_EMIT && st_d != ST_EMIT) begin
			o_row  <= i_q;
			o_col  <= j_q;
			o_re   <= rre;
			o_im   <= rim;
			o_sat  <= sre || sim;
			o_last <= last_i && last_j;
		end
	end

	`CHK_IMPL(a_no_job_busy, clk, arst_n, job_ready, st_q == ST_IDLE, "job taken while busy")
	`CHK_NEXT(a_hold_out, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`CHK_IMPL(a_mac_in_mac, clk, arst_n, mac_s2 && !fetch_s1, st_q == ST_MAC, "stray product")
endmodule
`default_nettype wire

// ===== rtl/core/complex_matrix_commutator.sv =====
// Channel | dir | tdata (low bit up)                                       | tuser
// s_axis  | in  | row, col, value_re, value_im, prior_re, prior_im, zeros | command
// m_axis  | out | out_row, out_col, out_re, out_im, zeros                 | saturated
//         |     | tlast = last_result                                     |
// A load is written into its store as the back end takes it. A compute runs per
// entry: a fetch of the prior, DIM k-steps of the eight-multiplier unit through
// the RAM read and product registers, then an emit once the output is free.
// arst_n clears control state; stores are undefined until written.
// A two-entry job queue lets the input side run on while results stall.
`default_nettype none
module complex_matrix_commutator
	import cmc_pkg::*;
#(
	parameter int MatrixDim = MatrixDimDef,
	parameter int FracBits  = FracBitsDef
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,  // row, col, value_re, value_im, prior_re, prior_im
	input  wire logic [1:0]   s_axis_tuser,  // command
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,  // out_row, out_col, out_re, out_im
	output logic [0:0]        m_axis_tuser,  // saturated
	output logic              m_axis_tlast   // last_result
);
	logic job_valid, job_ready;
	job_t job;
	logic [IdxW-1:0] o_row, o_col;
	logic [ValW-1:0] o_re, o_im;
	logic o_sat;

	cmc_front #(.MatrixDim(MatrixDim)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cmd(s_axis_tuser), .row(s_axis_tdata[1:0]), .col(s_axis_tdata[3:2]),
		.v_re(s_axis_tdata[35:4]), .v_im(s_axis_tdata[67:36]),
		.p_re(s_axis_tdata[99:68]), .p_im(s_axis_tdata[131:100]),
		.job_valid, .job_ready, .job
	);

	cmc_back #(.MatrixDim(MatrixDim), .FracBits(FracBits)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.o_row, .o_col, .o_re, .o_im, .o_sat, .o_last(m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, o_im, o_re, o_col, o_row};
	assign m_axis_tuser = o_sat;
endmodule
`default_nettype wire

// ===== tb/sv/tb_complex_matrix_commutator.sv =====
`default_nettype none
module tb_complex_matrix_commutator
	import cmc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = 4;
	localparam int RANDOM_ITEMS = 425;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		cmd_t cmd;
		logic [1:0] row;
		logic [1:0] col;
		logic [31:0] v_re;
		logic [31:0] v_im;
		logic [31:0] p_re;
		logic [31:0] p_im;
	} load_item_t;

	typedef struct {
		logic [1:0] row;
		logic [1:0] col;
		logic [31:0] re;
		logic [31:0] im;
		logic sat;
		logic last;
	} entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [135:0] s_axis_tdata = '0;  // row, col, value_re, value_im, prior_re, prior_im
	logic [1:0] s_axis_tuser = CMD_NOP;  // command
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;  // out_row, out_col, out_re, out_im
	logic [0:0] m_axis_tuser;  // saturated
	logic m_axis_tlast;  // last_result

	// predictor copy of the matrix stores
	logic signed [31:0] ham_re[16];
	logic signed [31:0] ham_im[16];
	logic signed [31:0] dens_re[16];
	logic signed [31:0] dens_im[16];
	logic signed [31:0] prior_re[16];
	logic signed [31:0] prior_im[16];

	entry_t expected_entries[$];
	load_item_t directed_rows[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	complex_matrix_commutator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL complex_matrix_commutator");
			$finish;
		end
	end

	function automatic longint fix_mul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> 16;  // floor
	endfunction

	function automatic logic [31:0] clip(longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	task automatic update_commutator(load_item_t it);
		int a;
		int ik;
		int kj;
		longint re;
		longint im;
		entry_t e;
		a = it.row * 4 + it.col;
		case (it.cmd)
			CMD_LOAD_H: begin
				ham_re[a] = it.v_re;
				ham_im[a] = it.v_im;
			end
			CMD_LOAD_S: begin
				dens_re[a] = it.v_re;
				dens_im[a] = it.v_im;
				prior_re[a] = it.p_re;
				prior_im[a] = it.p_im;
			end
			CMD_COMPUTE: begin
				for (int i = 0; i < DIM; i++) begin
					for (int j = 0; j < DIM; j++) begin
						re = prior_re[i*4+j];
						im = prior_im[i*4+j];
						for (int k = 0; k < DIM; k++) begin
							ik = i * 4 + k;
							kj = k * 4 + j;
							re += fix_mul(ham_re[ik], dens_im[kj]);
							re -= fix_mul(dens_re[ik], ham_im[kj]);
							re += fix_mul(ham_im[ik], dens_re[kj]);
							re -= fix_mul(dens_im[ik], ham_re[kj]);
							im -= fix_mul(ham_re[ik], dens_re[kj]);
							im += fix_mul(dens_re[ik], ham_re[kj]);
							im += fix_mul(ham_im[ik], dens_im[kj]);
							im -= fix_mul(dens_im[ik], ham_im[kj]);
						end
						e.row = i[1:0];
						e.col = j[1:0];
						e.sat = 1'b0;
						e.re = clip(re, e.sat);
						e.im = clip(im, e.sat);
						e.last = (i == DIM - 1 && j == DIM - 1);
						expected_entries.push_back(e);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(load_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.cmd;
		s_axis_tdata <= {4'b0, it.p_im, it.p_re, it.v_im, it.v_re, it.col, it.row};
		do @(posedge clk); while (!s_axis_tready);
		update_commutator(it);
	endtask

	// mostly extremes and small Q16.16 values, with full-range noise
	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	function automatic load_item_t rand_load(cmd_t c);
		load_item_t it;
		it.cmd = c;
		it.row = $urandom_range(0, 3);
		it.col = $urandom_range(0, 3);
		it.v_re = rand_value();
		it.v_im = rand_value();
		it.p_re = rand_value();
		it.p_im = rand_value();
		return it;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	always @(posedge clk) begin
		entry_t e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_entries.size() == 0) begin
					report("unexpected transaction", m_axis_tdata[35:4], 32'h0);
				end else begin
					e = expected_entries.pop_front();
					if (m_axis_tdata[1:0] !== e.row)
						report("out_row", 32'(m_axis_tdata[1:0]), 32'(e.row));
					if (m_axis_tdata[3:2] !== e.col)
						report("out_col", 32'(m_axis_tdata[3:2]), 32'(e.col));
					if (m_axis_tdata[35:4] !== e.re) report("out_re", m_axis_tdata[35:4], e.re);
					if (m_axis_tdata[67:36] !== e.im) report("out_im", m_axis_tdata[67:36], e.im);
					if (m_axis_tuser[0] !== e.sat)
						report("saturated", 32'(m_axis_tuser[0]), 32'(e.sat));
					if (m_axis_tlast !== e.last)
						report("last_result", 32'(m_axis_tlast), 32'(e.last));
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		load_item_t it;
		int sent;
		int burst;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every store entry is written before the first compute
		for (int a = 0; a < 16; a++) begin
			it = rand_load(CMD_LOAD_H);
			it.row = a / 4;
			it.col = a % 4;
			send_item(it);
			it = rand_load(CMD_LOAD_S);
			it.row = a / 4;
			it.col = a % 4;
			send_item(it);
		end

		// corners, saturation both ways, unused command, repeated compute
		directed_rows.push_back('{CMD_COMPUTE, 2'd0, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0});
		directed_rows.push_back('{CMD_LOAD_H, 2'd0, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0});
		directed_rows.push_back('{CMD_LOAD_S, 2'd0, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000});
		directed_rows.push_back('{CMD_LOAD_H, 2'd3, 2'd3, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0});
		directed_rows.push_back('{CMD_LOAD_S, 2'd3, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF});
		directed_rows.push_back('{CMD_LOAD_H, 2'd0, 2'd3, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0});
		directed_rows.push_back('{CMD_LOAD_S, 2'd3, 2'd0, 32'h0001_0000, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0});
		directed_rows.push_back('{CMD_NOP, 2'd1, 2'd2, 32'h1234_5678, 32'h0, 32'h0, 32'h0});
		directed_rows.push_back('{CMD_COMPUTE, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF});
		directed_rows.push_back('{CMD_COMPUTE, 2'd1, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0});
		directed_rows.push_back('{CMD_LOAD_S, 2'd1, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0});
		directed_rows.push_back('{CMD_LOAD_H, 2'd2, 2'd1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		directed_rows.push_back('{CMD_COMPUTE, 2'd2, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0});
		foreach (directed_rows[n]) send_item(directed_rows[n]);

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 82; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 82; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			if (phase == 2) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (expected_entries.size() != 0);
			end
			while (sent < (phase + 1) * RANDOM_ITEMS / 4) begin
				burst = $urandom_range(0, 12);
				for (int b = 0; b < burst; b++) begin
					it = rand_load($urandom_range(0, 9) < 8 ?
						($urandom_range(0, 1) ? CMD_LOAD_H : CMD_LOAD_S) : CMD_NOP);
					send_item(it);
					sent++;
				end
				send_item(rand_load(CMD_COMPUTE));
				sent++;
			end
		end
		s_axis_tvalid <= 1'b0;

		while (expected_entries.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS complex_matrix_commutator");
		end else begin
			$display("FAIL complex_matrix_commutator");
		end
		$finish;
	end
endmodule
`default_nettype wire
